@@ rtl/mean_shift_vector_top_macros.svh @@
// Assertion macros for the mean shift vector block.
// Included by the top level; no other dependencies.
`ifndef MEAN_SHIFT_VECTOR_TOP_MACROS_SVH
`define MEAN_SHIFT_VECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define MSV_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mean shift vector: property violated");
// Check that a condition never holds outside reset
`define MSV_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("mean shift vector: forbidden condition");
`else
`define MSV_ASSERT_PROP(label, prop)
`define MSV_ASSERT_NEVER(label, expr)
`endif
`endif

@@ rtl/msv_pkg.sv @@
// Shared types and constants of the mean shift vector block.
// No dependencies.
package msv_pkg;

    localparam int HUE_BINS      = 64;
    localparam int SAT_BINS      = 64;
    localparam int HUE_BIN_SIZE  = 4;
    localparam int SAT_BIN_SIZE  = 4;
    localparam int MAX_WINDOW    = 256;
    localparam int FRACTION_BITS = 24;

    localparam int BIN_DEPTH   = 4096;
    localparam int BIN_AW      = 12;
    localparam int BIN_W       = 24;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_W       = 9;
    localparam int DIV_STEPS   = 72;
    localparam int SQRT_STEPS  = 36;
    localparam int STEP_CNT_W  = 7;

    // item kinds
    localparam logic [1:0] KIND_TARGET    = 2'd0;
    localparam logic [1:0] KIND_CANDIDATE = 2'd1;
    localparam logic [1:0] KIND_PIXEL     = 2'd2;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RATIO_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MOM,
        OP_ACCUM,
        OP_COUNT,
        OP_OUTX_INIT,
        OP_SAVEX_INITY,
        OP_SAVE_Y,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_SQINIT,
        S_SQRT,
        S_MUL_LO,
        S_MUL_HI,
        S_MOM,
        S_ACCUM,
        S_COUNT,
        S_FIN,
        S_DIVX,
        S_SAVEX,
        S_DIVY,
        S_SAVEY,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cand_zero;
        logic wsum_zero;
        logic win_end;
    } dp_status_t;

endpackage

@@ rtl/msv_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module msv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/msv_ctrl.sv @@
// Controller state machine of the mean shift vector block.
// Depends on msv_pkg; drives the datapath through dp_cmd_t.
module msv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic [1:0]          s_tuser,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output msv_pkg::dp_cmd_t    cmd,
    input  msv_pkg::dp_status_t status
);
    import msv_pkg::*;

    ctl_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // hold state, step counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // sequence one request through the datapath
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = OP_NONE;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_ACCEPT;
                    if (s_tuser == KIND_PIXEL) begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                cnt_next = '0;
                if (status.cand_zero) begin
                    state_next = S_COUNT;
                end else begin
                    cmd.op     = OP_RATIO_INIT;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_SQINIT;
                end
            end
            S_SQINIT: begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(SQRT_STEPS - 1)) begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = S_MOM;
            end
            S_MOM: begin
                cmd.op     = OP_MOM;
                state_next = S_ACCUM;
            end
            S_ACCUM: begin
                cmd.op     = OP_ACCUM;
                state_next = S_COUNT;
            end
            S_COUNT: begin
                cmd.op     = OP_COUNT;
                state_next = status.win_end ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                cnt_next = '0;
                if (status.wsum_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_OUTX_INIT;
                    state_next = S_DIVX;
                end
            end
            S_DIVX: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_SAVEX;
                end
            end
            S_SAVEX: begin
                cmd.op     = OP_SAVEX_INITY;
                cnt_next   = '0;
                state_next = S_DIVY;
            end
            S_DIVY: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_SAVEY;
                end
            end
            S_SAVEY: begin
                cmd.op     = OP_SAVE_Y;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = OP_EMIT;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/msv_datapath.sv @@
// Datapath: bin stores, shared divider/square root, weights and moment sums.
// Depends on msv_pkg and msv_ram; commanded by msv_ctrl.
module msv_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  msv_pkg::dp_cmd_t             cmd,
    output msv_pkg::dp_status_t          status,
    input  logic [msv_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [msv_pkg::CFG_W-1:0]    cfg_data,
    output logic [msv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                         m_tuser
);
    import msv_pkg::*;

    // input fields
    logic [BIN_AW-1:0] in_addr;
    logic [BIN_W-1:0]  in_value;
    logic [7:0]        in_hue, in_sat;
    logic [BIN_W-1:0]  in_kernel;
    assign in_addr   = s_tdata[11:0];
    assign in_value  = s_tdata[35:12];
    assign in_hue    = s_tdata[43:36];
    assign in_sat    = s_tdata[51:44];
    assign in_kernel = s_tdata[75:52];

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [7:0]       col_reg, row_reg;
    logic [39:0]      wsum_reg;
    logic signed [47:0] momx_reg, momy_reg;
    logic [71:0]      acc_reg;
    logic [39:0]      rem_reg, div_reg;
    logic [35:0]      root_reg;
    logic [BIN_W-1:0] kern_reg;
    logic [59:0]      prod_reg;
    logic signed [45:0] mx_reg, my_reg;
    logic             neg_reg;
    logic [15:0]      qx_reg, qy_reg;
    logic [15:0]      out_x_reg, out_y_reg;
    logic             out_flag_reg;

    // bin lookup address of a pixel
    logic [7:0]        hb_raw, sb_raw, hb, sb;
    logic [15:0]       pix_addr_full;
    logic [BIN_AW-1:0] pix_addr;
    assign hb_raw = 8'(in_hue / HUE_BIN_SIZE);
    assign sb_raw = 8'(in_sat / SAT_BIN_SIZE);
    assign hb = (hb_raw > 8'(HUE_BINS - 1)) ? 8'(HUE_BINS - 1) : hb_raw;
    assign sb = (sb_raw > 8'(SAT_BINS - 1)) ? 8'(SAT_BINS - 1) : sb_raw;
    assign pix_addr_full = 16'(hb) * 16'(SAT_BINS) + 16'(sb);
    assign pix_addr = pix_addr_full[BIN_AW-1:0];

    // bin stores
    logic             accept;
    logic [BIN_W-1:0] tgt_rdata, cand_rdata;
    assign accept = (cmd.op == OP_ACCEPT);

    msv_ram #(.WIDTH(BIN_W), .DEPTH(BIN_DEPTH)) u_target_ram (
        .clk   (aclk),
        .we    (accept && s_tuser == KIND_TARGET),
        .waddr (in_addr),
        .wdata (in_value),
        .re    (accept && s_tuser == KIND_PIXEL),
        .raddr (pix_addr),
        .rdata (tgt_rdata)
    );

    msv_ram #(.WIDTH(BIN_W), .DEPTH(BIN_DEPTH)) u_candidate_ram (
        .clk   (aclk),
        .we    (accept && s_tuser == KIND_CANDIDATE),
        .waddr (in_addr),
        .wdata (in_value),
        .re    (accept && s_tuser == KIND_PIXEL),
        .raddr (pix_addr),
        .rdata (cand_rdata)
    );

    // effective window and pixel offsets
    logic [CFG_W-1:0] w_eff, h_eff, cx_full, cy_full;
    logic [CFG_W-1:0] col_inc, row_inc;
    logic signed [8:0] dx, dy;
    assign w_eff = (width_reg == '0) ? CFG_W'(1) :
                   (width_reg > CFG_W'(MAX_WINDOW)) ? CFG_W'(MAX_WINDOW) : width_reg;
    assign h_eff = (height_reg == '0) ? CFG_W'(1) :
                   (height_reg > CFG_W'(MAX_WINDOW)) ? CFG_W'(MAX_WINDOW) : height_reg;
    assign cx_full = (w_eff - 1'b1) >> 1;
    assign cy_full = (h_eff - 1'b1) >> 1;
    assign dx = $signed({1'b0, col_reg}) - $signed(cx_full);
    assign dy = $signed({1'b0, row_reg}) - $signed(cy_full);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    // restoring divide step
    logic [40:0] div_shift;
    logic [40:0] div_diff;
    logic        div_ge;
    assign div_shift = {rem_reg, acc_reg[71]};
    assign div_diff  = div_shift - {1'b0, div_reg};
    assign div_ge    = (div_shift >= {1'b0, div_reg});

    // square root step, two radicand bits at a time
    logic [39:0] sq_shift, sq_trial, sq_diff;
    logic        sq_ge;
    assign sq_shift = {rem_reg[37:0], acc_reg[71:70]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_diff  = sq_shift - sq_trial;
    assign sq_ge    = (sq_shift >= sq_trial);

    // weight and moment products
    logic [35:0]        wt;
    logic [41:0]        pp_lo, pp_hi;
    logic signed [45:0] wt_s, dx_s, dy_s, mx_calc, my_calc;
    assign wt    = prod_reg[59:24];
    assign pp_lo = 42'(kern_reg) * 42'(root_reg[17:0]);
    assign pp_hi = 42'(kern_reg) * 42'(root_reg[35:18]);
    assign wt_s  = $signed({10'b0, wt});
    assign dx_s  = 46'(dx);
    assign dy_s  = 46'(dy);
    assign mx_calc = wt_s * dx_s;
    assign my_calc = wt_s * dy_s;

    // saturating accumulation
    logic [40:0]        wsum_add;
    logic [39:0]        wsum_sat;
    logic signed [48:0] momx_add, momy_add;
    logic signed [47:0] momx_sat, momy_sat;
    assign wsum_add = {1'b0, wsum_reg} + {5'b0, wt};
    assign wsum_sat = wsum_add[40] ? '1 : wsum_add[39:0];
    assign momx_add = {momx_reg[47], momx_reg} + {{3{mx_reg[45]}}, mx_reg};
    assign momy_add = {momy_reg[47], momy_reg} + {{3{my_reg[45]}}, my_reg};
    assign momx_sat = (momx_add[48] != momx_add[47]) ?
                      (momx_add[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : momx_add[47:0];
    assign momy_sat = (momy_add[48] != momy_add[47]) ?
                      (momy_add[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : momy_add[47:0];

    // magnitude of moment times 256 for the output divide
    logic [55:0] magx, magy;
    assign magx = momx_reg[47] ? (56'd0 - {momx_reg, 8'b0}) : {momx_reg, 8'b0};
    assign magy = momy_reg[47] ? (56'd0 - {momy_reg, 8'b0}) : {momy_reg, 8'b0};

    // signed, saturated result from a quotient magnitude
    function automatic logic [15:0] shift_sat(input logic [71:0] q, input logic neg);
        logic [15:0] r;
        if (neg) begin
            r = (q > 72'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
        end else begin
            r = (q > 72'd32767) ? 16'h7fff : q[15:0];
        end
        return r;
    endfunction

    // control state: window registers, counters, accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            wsum_reg   <= '0;
            momx_reg   <= '0;
            momy_reg   <= '0;
        end else begin
            if (cfg_we && cfg_index == CFG_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_HEIGHT) begin
                height_reg <= cfg_data;
            end
            case (cmd.op)
                OP_ACCUM: begin
                    wsum_reg <= wsum_sat;
                    momx_reg <= momx_sat;
                    momy_reg <= momy_sat;
                end
                OP_COUNT: begin
                    if (col_inc >= w_eff) begin
                        col_reg <= '0;
                        row_reg <= (row_inc >= h_eff) ? 8'd0 : row_inc[7:0];
                    end else begin
                        col_reg <= col_inc[7:0];
                    end
                end
                OP_EMIT: begin
                    wsum_reg <= '0;
                    momx_reg <= '0;
                    momy_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // arithmetic payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                kern_reg <= in_kernel;
            end
            OP_RATIO_INIT: begin
                acc_reg <= {tgt_rdata, 48'b0};
                div_reg <= {16'b0, cand_rdata};
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? div_diff[39:0] : div_shift[39:0];
                acc_reg <= {acc_reg[70:0], div_ge};
            end
            OP_SQRT_INIT: begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP: begin
                rem_reg  <= sq_ge ? sq_diff : sq_shift;
                root_reg <= {root_reg[34:0], sq_ge};
                acc_reg  <= {acc_reg[69:0], 2'b00};
            end
            OP_MUL_LO: begin
                prod_reg <= 60'(pp_lo);
            end
            OP_MUL_HI: begin
                prod_reg <= prod_reg + {pp_hi, 18'b0};
            end
            OP_MOM: begin
                mx_reg <= mx_calc;
                my_reg <= my_calc;
            end
            OP_OUTX_INIT: begin
                acc_reg <= {16'b0, magx};
                div_reg <= wsum_reg;
                rem_reg <= '0;
                neg_reg <= momx_reg[47];
            end
            OP_SAVEX_INITY: begin
                qx_reg  <= shift_sat(acc_reg, neg_reg);
                acc_reg <= {16'b0, magy};
                rem_reg <= '0;
                neg_reg <= momy_reg[47];
            end
            OP_SAVE_Y: begin
                qy_reg <= shift_sat(acc_reg, neg_reg);
            end
            OP_EMIT: begin
                out_x_reg    <= (wsum_reg == '0) ? 16'd0 : qx_reg;
                out_y_reg    <= (wsum_reg == '0) ? 16'd0 : qy_reg;
                out_flag_reg <= (wsum_reg == '0);
            end
            default: begin
            end
        endcase
    end

    assign status.cand_zero = (cand_rdata == '0);
    assign status.wsum_zero = (wsum_reg == '0);
    assign status.win_end   = (col_inc >= w_eff) && (row_inc >= h_eff);

    assign m_tdata = {out_y_reg, out_x_reg};
    assign m_tuser = out_flag_reg;

endmodule

@@ rtl/mean_shift_vector_top.sv @@
// Mean shift vector: loads write a bin store; a pixel whose candidate bin is zero
// skips the weights, others run a 72-step divider, 36-step square root and two
// multiply passes. The last pixel of a window adds the two output divides on the
// same divider; the result then waits in an output register while the next
// request is taken. Reset is synchronous, active low, and clears counters and sums;
// the bin stores are not cleared and need no clearing pass.
module mean_shift_vector_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bin_address[11:0], bin_value[35:12], hue[43:36], saturation[51:44],
    // kernel_weight[75:52], zero fill
    input  logic [msv_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // shift_x[15:0], shift_y[31:16]
    output logic [msv_pkg::M_TDATA_W-1:0] m_tdata,
    // no_weight[0]
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [msv_pkg::CFG_W-1:0]     cfg_data
);
    import msv_pkg::*;
    `include "mean_shift_vector_top_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t status;

    msv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    msv_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // the block is busy in the cycle after a pixel request is accepted
    `MSV_ASSERT_PROP(a_pixel_busy, s_tvalid && s_tready && s_tuser == KIND_PIXEL |=> !s_tready)
    // a result is only produced out of the busy sequence
    `MSV_ASSERT_PROP(a_emit_busy, $rose(m_tvalid) |-> $past(!s_tready))
    // a flagged result carries zero shifts
    `MSV_ASSERT_NEVER(a_flag_zero, m_tvalid && m_tuser && m_tdata != '0)
    // the output divide never starts from an empty weight sum
    `MSV_ASSERT_NEVER(a_div_nonzero, cmd.op == OP_OUTX_INIT && status.wsum_zero)

endmodule
